// ===== rtl/hse_pkg.sv =====
// Package for the heap sort engine: shared widths, the datapath command code
// and the status group returned to the controller. No dependencies.
package hse_pkg;

  localparam int KEY_W        = 32;
  localparam int CAPACITY_DEF = 32;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_BUILD_INIT,
    DP_BUILD_NEXT,
    DP_HELD_RD,
    DP_HELD_LD,
    DP_CHILD_RD,
    DP_CMP,
    DP_FIN,
    DP_SORT_INIT,
    DP_SWAP_RD,
    DP_SWAP_WR,
    DP_EMIT_INIT,
    DP_EMIT_RD,
    DP_EMIT_LD,
    DP_CLEAR
  } hse_cmd_t;

  typedef struct packed {
    logic full;
    logic n_zero;
    logic n_le1;
    logic child_gt_size;
    logic stop;
    logic emit_done;
  } hse_sts_t;

endpackage

// ===== rtl/hse_datapath.sv =====
// Datapath of the heap sort engine: key store, sift-down registers and the
// result register. Depends on hse_pkg; driven by hse_ctrl commands.
module hse_datapath
  import hse_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hse_cmd_t                cmd,
  output hse_sts_t                sts,
  input  logic signed [KEY_W-1:0] in_key_value,
  output logic signed [KEY_W-1:0] out_sorted_value,
  output logic                    out_last_sorted
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = CNT_W + 1;

  logic signed [KEY_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        size_r;
  logic [CNT_W-1:0]        n_r;
  logic [CNT_W-1:0]        node_r;
  logic signed [KEY_W-1:0] held_r;
  logic signed [KEY_W-1:0] rdata_a_r;
  logic signed [KEY_W-1:0] rdata_b_r;
  logic signed [KEY_W-1:0] out_value_r;
  logic                    out_last_r;

  logic [CW-1:0]           child;
  logic [CW-1:0]           size_ext;
  logic [CW-1:0]           left_idx;
  logic [CW-1:0]           right_idx;
  logic [CW-1:0]           big_node;
  logic                    has_right;
  logic                    big_right;
  logic signed [KEY_W-1:0] big;
  logic                    stop;
  logic [CNT_W-1:0]        n_dec;
  logic [CNT_W-1:0]        node_dec;
  logic [AW-1:0]           rd_addr_a;
  logic [AW-1:0]           rd_addr_b;
  logic                    we;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  always_comb begin
    child     = {node_r, 1'b0};
    size_ext  = {1'b0, size_r};
    has_right = child < size_ext;
    left_idx  = child - CW'(1);
    right_idx = has_right ? child : left_idx;
    big_right = has_right && (rdata_b_r > rdata_a_r);
    big       = big_right ? rdata_b_r : rdata_a_r;
    big_node  = big_right ? (child + CW'(1)) : child;
    stop      = !(big > held_r);
    n_dec     = n_r - CNT_W'(1);
    node_dec  = node_r - CNT_W'(1);
  end

  always_comb begin
    sts.full          = (cnt_r == CNT_W'(CAPACITY - 1));
    sts.n_zero        = (n_r == '0);
    sts.n_le1         = (n_r <= CNT_W'(1));
    sts.child_gt_size = child > size_ext;
    sts.stop          = stop;
    sts.emit_done     = (n_r == cnt_r);
  end

  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = '0;
    we        = 1'b0;
    wr_addr   = '0;
    wr_data   = held_r;
    unique case (cmd)
      DP_HELD_RD:  rd_addr_a = n_dec[AW-1:0];
      DP_CHILD_RD: begin
        rd_addr_a = left_idx[AW-1:0];
        rd_addr_b = right_idx[AW-1:0];
      end
      DP_SWAP_RD:  rd_addr_b = n_dec[AW-1:0];
      DP_EMIT_RD:  rd_addr_a = n_r[AW-1:0];
      DP_LOAD: begin
        we      = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        wr_data = in_key_value;
      end
      DP_FIN: begin
        we      = 1'b1;
        wr_addr = node_dec[AW-1:0];
      end
      DP_CMP: begin
        we      = 1'b1;
        wr_addr = node_dec[AW-1:0];
        wr_data = stop ? held_r : big;
      end
      DP_SWAP_WR: begin
        we      = 1'b1;
        wr_addr = n_dec[AW-1:0];
        wr_data = rdata_a_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_a_r <= mem[rd_addr_a];
    rdata_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      unique case (cmd)
        DP_LOAD:  cnt_r <= cnt_r + CNT_W'(1);
        DP_CLEAR: cnt_r <= '0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      DP_BUILD_INIT: begin
        size_r <= cnt_r;
        n_r    <= cnt_r >> 1;
      end
      DP_BUILD_NEXT: n_r <= n_dec;
      DP_HELD_RD:    node_r <= n_r;
      DP_HELD_LD:    held_r <= rdata_a_r;
      DP_CMP: begin
        if (!stop) begin
          node_r <= big_node[CNT_W-1:0];
        end
      end
      DP_SORT_INIT:  n_r <= cnt_r;
      DP_SWAP_WR: begin
        held_r <= rdata_b_r;
        node_r <= CNT_W'(1);
        size_r <= n_dec;
        n_r    <= n_dec;
      end
      DP_EMIT_INIT:  n_r <= '0;
      DP_EMIT_LD: begin
        out_value_r <= rdata_a_r;
        out_last_r  <= ((n_r + CNT_W'(1)) == cnt_r);
        n_r         <= n_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_sorted_value = out_value_r;
  assign out_last_sorted  = out_last_r;

endmodule

// ===== rtl/hse_ctrl.sv =====
// Controller of the heap sort engine: loading, heap build, sort-down and
// emission sequence. Depends on hse_pkg; commands hse_datapath.
module hse_ctrl
  import hse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_key,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  hse_sts_t sts,
  output hse_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_BINIT,
    S_BCHK,
    S_HLD,
    S_SLOOP,
    S_CMP,
    S_BNEXT,
    S_SINIT,
    S_SCHK,
    S_SWP,
    S_EINIT,
    S_ERD,
    S_ELD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   building_r, building_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && (state_r == S_LOAD);

  always_comb begin
    state_nxt     = state_r;
    building_nxt  = building_r;
    out_valid_nxt = out_valid_r;
    cmd           = DP_NOP;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cmd = DP_LOAD;
          if (in_last_key || sts.full) begin
            state_nxt = S_BINIT;
          end
        end
      end
      S_BINIT: begin
        cmd          = DP_BUILD_INIT;
        building_nxt = 1'b1;
        state_nxt    = S_BCHK;
      end
      S_BCHK: begin
        if (sts.n_zero) begin
          state_nxt = S_SINIT;
        end else begin
          cmd       = DP_HELD_RD;
          state_nxt = S_HLD;
        end
      end
      S_HLD: begin
        cmd       = DP_HELD_LD;
        state_nxt = S_SLOOP;
      end
      S_SLOOP: begin
        if (sts.child_gt_size) begin
          cmd       = DP_FIN;
          state_nxt = building_r ? S_BNEXT : S_SCHK;
        end else begin
          cmd       = DP_CHILD_RD;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd = DP_CMP;
        if (sts.stop) begin
          state_nxt = building_r ? S_BNEXT : S_SCHK;
        end else begin
          state_nxt = S_SLOOP;
        end
      end
      S_BNEXT: begin
        cmd       = DP_BUILD_NEXT;
        state_nxt = S_BCHK;
      end
      S_SINIT: begin
        cmd          = DP_SORT_INIT;
        building_nxt = 1'b0;
        state_nxt    = S_SCHK;
      end
      S_SCHK: begin
        if (sts.n_le1) begin
          state_nxt = S_EINIT;
        end else begin
          cmd       = DP_SWAP_RD;
          state_nxt = S_SWP;
        end
      end
      S_SWP: begin
        cmd       = DP_SWAP_WR;
        state_nxt = S_SLOOP;
      end
      S_EINIT: begin
        cmd       = DP_EMIT_INIT;
        state_nxt = S_ERD;
      end
      S_ERD: begin
        cmd       = DP_EMIT_RD;
        state_nxt = S_ELD;
      end
      S_ELD: begin
        cmd           = DP_EMIT_LD;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (sts.emit_done) begin
            cmd       = DP_CLEAR;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      building_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      building_r  <= building_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/heap_sort_engine_unit.sv =====
// Heap sort engine, top level: joins hse_ctrl and hse_datapath.
// Depends on hse_pkg.
//
// Keys load one beat per cycle into a CAPACITY-entry store; a beat with
// in_last_key set, or the beat that fills the store, ends the set. The block
// then builds a max-heap and sorts in place, stalling input, and sends the
// keys as beats in ascending order with out_last_sorted on the greatest one.
// Sorting runs each sift-down level by level, plus the swaps, through a store
// with two read ports and one write port; emission reads, loads and presents
// one beat at a time and holds it while the output is stalled.
module heap_sort_engine_unit
  import hse_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [KEY_W-1:0] in_key_value,
  input  logic                    in_last_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [KEY_W-1:0] out_sorted_value,
  output logic                    out_last_sorted
);

  hse_cmd_t cmd;
  hse_sts_t sts;

  hse_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_key (in_last_key),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  hse_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_key_value     (in_key_value),
    .out_sorted_value (out_sorted_value),
    .out_last_sorted  (out_last_sorted)
  );

endmodule
